>>> rtl/rffd_pkg.sv
`timescale 1ns / 1ps

package rffd_pkg;

  localparam int MAX_SERVERS_DEF  = 16;
  localparam int SERVER_COUNT_RST = 16;
  localparam int CFG_W            = 5;
  localparam int TIME_W           = 31;
  localparam int BUSY_W           = 32;
  localparam int GRANT_W          = 32;
  localparam int INDEX_W          = 4;
  localparam int IN_TDATA_W       = 64;
  localparam int OUT_TDATA_W      = 40;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_COMMIT,
    CELL_ROTATE,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     active;
    logic     pick;
    logic     wrap;
  } cell_ctl_t;

endpackage

>>> rtl/rotating_first_free_dispatcher_top.sv
`timescale 1ns / 1ps

// Dispatcher that hands requests to a row of servers, first free one at or
// after a rotating start position. A request enters on the s_axis channel and
// one result item per request leaves on m_axis. The cfg channel sets the
// number of servers in use and is always ready; it is to be written only
// when idle, which the block itself does not enforce. A request passes an
// accept cycle, where every server cell compares its busy-until time with the
// arrival, and a pick cycle, where the rotating search commits the choice.
// Its result is valid on the next cycle. A request marked last is followed by
// a report: the server counts rotate once around the ring of active cells to
// find the maximum, then once more to list every server that holds it, and
// the state clears in the same cycle as the last step. The output register
// lets the next request be accepted while a result waits. When the receiver
// stalls, the pick step and the report steps that emit an item wait for the
// output register. Reset clears all servers, the start position and the
// output, and sets the server count to SERVER_COUNT_RST, at most MAX_SERVERS.

module rotating_first_free_dispatcher_top
  import rffd_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // arrival_time, work_load
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // server_index, dropped, grant_total
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int K_RST = (SERVER_COUNT_RST > MAX_SERVERS) ? MAX_SERVERS : SERVER_COUNT_RST;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_MAX,
    ST_REPORT
  } state_t;

  state_t state;
  logic [CNT_W-1:0]   k;
  logic [IDX_W-1:0]   start_pos;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   top_idx;
  logic [GRANT_W-1:0] top;
  logic [BUSY_W-1:0]  busy_value;
  logic               last_req;

  logic               out_valid;
  logic               out_kind;
  logic [INDEX_W-1:0] out_idx;
  logic               out_drop;
  logic [GRANT_W-1:0] out_total;
  logic               out_last;

  cell_op_t                 op;
  cell_ctl_t                ctl [MAX_SERVERS];
  logic [MAX_SERVERS-1:0]   free;
  logic [GRANT_W-1:0]       grant [MAX_SERVERS];
  logic [MAX_SERVERS-1:0]   onehot;
  logic                     found;
  logic [IDX_W-1:0]         pick_idx;
  logic [GRANT_W-1:0]       pick_total;
  logic [IDX_W-1:0]         start;
  logic [IDX_W-1:0]         start_next;
  logic [GRANT_W-1:0]       head;
  logic                     in_fire;
  logic                     slot_free;
  logic                     cnt_end;
  logic                     hit;
  logic                     advance;
  logic                     out_load;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid || m_axis_tready;
  assign head          = grant[0];
  assign cnt_end       = (CNT_W'(cnt) == k - CNT_W'(1));
  assign hit           = (head == top);
  assign advance       = !hit || slot_free;
  assign out_load      = ((state == ST_PICK) && slot_free)
                      || ((state == ST_REPORT) && hit && slot_free);

  assign start      = (CNT_W'(start_pos) < k) ? start_pos : '0;
  assign start_next = ((CNT_W'(start) + CNT_W'(1)) >= k) ? '0 : start + IDX_W'(1);

  always_comb begin
    op = CELL_HOLD;
    case (state)
      ST_IDLE:   op = in_fire ? CELL_CMP : CELL_HOLD;
      ST_PICK:   op = slot_free ? CELL_COMMIT : CELL_HOLD;
      ST_MAX:    op = CELL_ROTATE;
      ST_REPORT: op = !advance ? CELL_HOLD : (cnt_end ? CELL_CLEAR : CELL_ROTATE);
      default:   op = CELL_HOLD;
    endcase
  end

  rffd_pick #(
    .N     (MAX_SERVERS),
    .IDX_W (IDX_W)
  ) u_pick (
    .free   (free),
    .start  (start),
    .onehot (onehot),
    .found  (found),
    .index  (pick_idx)
  );

  always_comb begin
    pick_total = '0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      pick_total = pick_total | (onehot[i] ? ((&grant[i]) ? grant[i] :
                                              grant[i] + GRANT_W'(1)) : '0);
    end
  end

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    assign ctl[i].op     = op;
    assign ctl[i].active = (CNT_W'(i) < k);
    assign ctl[i].pick   = onehot[i];
    assign ctl[i].wrap   = (CNT_W'(i) == k - CNT_W'(1));

    rffd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[i]),
      .arrival     (s_axis_tdata[TIME_W-1:0]),
      .busy_value  (busy_value),
      .head_grant  (head),
      .right_grant (grant[(i + 1) % MAX_SERVERS]),
      .free        (free[i]),
      .grant       (grant[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= CNT_W'(K_RST);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        k <= CNT_W'(1);
      end else if (int'(cfg_data) > MAX_SERVERS) begin
        k <= CNT_W'(MAX_SERVERS);
      end else begin
        k <= CNT_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start_pos <= '0;
      cnt       <= '0;
      top_idx   <= '0;
      top       <= '0;
      last_req  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            busy_value <= BUSY_W'(s_axis_tdata[TIME_W-1:0])
                        + BUSY_W'(s_axis_tdata[2*TIME_W-1:TIME_W]);
            last_req   <= s_axis_tlast;
            state      <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (slot_free) begin
            out_kind  <= KIND_ASSIGN;
            out_idx   <= found ? INDEX_W'(pick_idx) : '0;
            out_drop  <= !found;
            out_total <= found ? pick_total : '0;
            out_last  <= !last_req;
            start_pos <= start_next;
            cnt       <= '0;
            top       <= '0;
            top_idx   <= '0;
            state     <= last_req ? ST_MAX : ST_IDLE;
          end
        end
        ST_MAX: begin
          if (head >= top) begin
            top     <= head;
            top_idx <= cnt;
          end
          if (cnt_end) begin
            cnt   <= '0;
            state <= ST_REPORT;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        ST_REPORT: begin
          if (hit && slot_free) begin
            out_kind  <= KIND_REPORT;
            out_idx   <= INDEX_W'(cnt);
            out_drop  <= 1'b0;
            out_total <= top;
            out_last  <= (cnt == top_idx);
          end
          if (advance) begin
            if (cnt_end) begin
              start_pos <= '0;
              state     <= ST_IDLE;
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - GRANT_W - INDEX_W - 1)'(0), out_total, out_drop, out_idx};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

>>> rtl/rffd_cell.sv
`timescale 1ns / 1ps

module rffd_cell
  import rffd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic [TIME_W-1:0]  arrival,
  input  logic [BUSY_W-1:0]  busy_value,
  input  logic [GRANT_W-1:0] head_grant,
  input  logic [GRANT_W-1:0] right_grant,
  output logic               free,
  output logic [GRANT_W-1:0] grant
);

  logic [BUSY_W-1:0]  busy;
  logic [GRANT_W-1:0] grant_inc;

  assign grant_inc = (&grant) ? grant : grant + GRANT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= '0;
      grant <= '0;
      free  <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_CMP: begin
          free <= ctl.active && (busy <= {1'b0, arrival});
        end
        CELL_COMMIT: begin
          if (ctl.pick) begin
            busy  <= busy_value;
            grant <= grant_inc;
          end else if (free) begin
            busy <= '0;
          end
        end
        CELL_ROTATE: begin
          if (ctl.active) begin
            grant <= ctl.wrap ? head_grant : right_grant;
          end
        end
        CELL_CLEAR: begin
          busy  <= '0;
          grant <= '0;
          free  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/rffd_pick.sv
`timescale 1ns / 1ps

module rffd_pick
  import rffd_pkg::*;
#(
  parameter int N     = MAX_SERVERS_DEF,
  parameter int IDX_W = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]     free,
  input  logic [IDX_W-1:0] start,
  output logic [N-1:0]     onehot,
  output logic             found,
  output logic [IDX_W-1:0] index
);

  logic [N-1:0] ahead;
  logic [N-1:0] masked;
  logic [N-1:0] sel;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ahead[i] = (IDX_W'(i) >= start);
    end
  end

  assign masked = free & ahead;
  assign sel    = (|masked) ? masked : free;
  assign onehot = sel & (~sel + N'(1));
  assign found  = |free;

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      index = index | (onehot[i] ? IDX_W'(i) : '0);
    end
  end

endmodule

>>> rtl/rffd_checker.sv
`timescale 1ns / 1ps

module rffd_checker
  import rffd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Stalled result item changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input item accepted while the previous one is still in work.");

  a_report_not_dropped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_REPORT |-> !m_axis_tdata[INDEX_W])
    else $error("Report item marked as dropped.");

  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[INDEX_W] |-> m_axis_tuser == KIND_ASSIGN
      && m_axis_tdata[INDEX_W-1:0] == '0
      && m_axis_tdata[INDEX_W+GRANT_W:INDEX_W+1] == '0)
    else $error("Dropped item carries a server or a count.");

  a_grant_counted: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_ASSIGN && !m_axis_tdata[INDEX_W]
      |-> m_axis_tdata[INDEX_W+GRANT_W:INDEX_W+1] != '0)
    else $error("Granted item shows a zero count.");

endmodule

bind rotating_first_free_dispatcher_top rffd_checker u_rffd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> sim/tb_rotating_first_free_dispatcher_top.sv
`timescale 1ns / 1ps

module tb_rotating_first_free_dispatcher_top;
  import rffd_pkg::*;

  localparam int NSRV        = MAX_SERVERS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] load;
    logic              last;
  } request_t;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
    logic               dropped;
    logic [GRANT_W-1:0] total;
    logic               last;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  rotating_first_free_dispatcher_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  request_t pending_requests[$];
  result_t  predicted_results[$];

  logic [BUSY_W-1:0]  busy_until_q[NSRV];
  logic [GRANT_W-1:0] grants_q[NSRV];
  int unsigned        start_pos = 0;
  logic [CFG_W-1:0]   server_count_q = SERVER_COUNT_RST[CFG_W-1:0];

  int  mismatches = 0;
  int  cycles = 0;
  int  requests_queued = 0;
  int  requests_seen = 0;
  int  results_seen = 0;
  int  drops_seen = 0;
  int  report_entries = 0;
  int  batches_closed = 0;
  int  settings_used = 1;
  bit  req_done = 1'b0;
  bit  cfg_done = 1'b0;
  bit  no_idle = 1'b0;

  logic [TIME_W-1:0] arrival_base = '0;
  int                batch_left = 4;

  task automatic report_mismatch(input string msg);
    $display("Mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic clear_servers();
    for (int i = 0; i < NSRV; i++) begin
      busy_until_q[i] = '0;
      grants_q[i] = '0;
    end
    start_pos = 0;
  endtask

  // Works out the results of one accepted request and queues them in order.
  task automatic dispatch_request(input request_t req);
    int unsigned k;
    int unsigned first;
    int unsigned s;
    int unsigned pick;
    logic [GRANT_W-1:0] top;
    logic [BUSY_W-1:0] arr;
    logic found;
    result_t r;
    arr = {1'b0, req.arrival};
    k = (server_count_q == 0) ? 1 : (server_count_q > NSRV) ? NSRV : server_count_q;
    first = (start_pos < k) ? start_pos : 0;
    found = 1'b0;
    pick = 0;
    for (int i = 0; i < k; i++) begin
      if (busy_until_q[i] <= arr) busy_until_q[i] = '0;
    end
    for (int n = 0; n < k; n++) begin
      s = first + n;
      if (s >= k) s -= k;
      if (!found && busy_until_q[s] <= arr) begin
        pick = s;
        found = 1'b1;
      end
    end
    r.kind = KIND_ASSIGN;
    r.last = !req.last;
    if (found) begin
      busy_until_q[pick] = arr + {1'b0, req.load};
      if (grants_q[pick] != {GRANT_W{1'b1}}) grants_q[pick] = grants_q[pick] + GRANT_W'(1);
      r.index = pick[INDEX_W-1:0];
      r.dropped = 1'b0;
      r.total = grants_q[pick];
    end else begin
      r.index = '0;
      r.dropped = 1'b1;
      r.total = '0;
      drops_seen++;
    end
    predicted_results.insert(predicted_results.size(), r);
    start_pos = (first + 1 >= k) ? 0 : first + 1;
    if (req.last) begin
      top = '0;
      for (int i = 0; i < k; i++) begin
        if (grants_q[i] > top) top = grants_q[i];
      end
      for (int i = 0; i < k; i++) begin
        if (grants_q[i] == top) begin
          r.kind = KIND_REPORT;
          r.index = i[INDEX_W-1:0];
          r.dropped = 1'b0;
          r.total = top;
          r.last = 1'b0;
          predicted_results.insert(predicted_results.size(), r);
          report_entries++;
        end
      end
      predicted_results[predicted_results.size() - 1].last = 1'b1;
      clear_servers();
      batches_closed++;
    end
  endtask

  always @(posedge clk) begin : monitor
    request_t req;
    result_t  got;
    result_t  want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, predicted_results.size());
      $display("FAILURE");
      $finish;
    end
    req_done <= s_axis_tvalid && s_axis_tready && !rst;
    cfg_done <= cfg_valid && cfg_ready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) server_count_q = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        req.arrival = s_axis_tdata[TIME_W-1:0];
        req.load = s_axis_tdata[2*TIME_W-1:TIME_W];
        req.last = s_axis_tlast;
        dispatch_request(req);
        requests_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.index = m_axis_tdata[INDEX_W-1:0];
        got.dropped = m_axis_tdata[INDEX_W];
        got.total = m_axis_tdata[INDEX_W+GRANT_W:INDEX_W+1];
        got.kind = m_axis_tuser;
        got.last = m_axis_tlast;
        results_seen++;
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d index %0d total %0d",
                                    got.kind, got.index, got.total));
        end else begin
          want = predicted_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
          if (got.index !== want.index)
            report_mismatch($sformatf("server_index %0d, expected %0d", got.index, want.index));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped %0d, expected %0d", got.dropped, want.dropped));
          if (got.total !== want.total)
            report_mismatch($sformatf("grant_total %0d, expected %0d", got.total, want.total));
          if (got.last !== want.last)
            report_mismatch($sformatf("last_of_run %0d, expected %0d", got.last, want.last));
        end
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk) begin : request_driver
    int gap_left;
    request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_axis_tvalid || req_done) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        s_axis_tdata <= {2'b00, req.load, req.arrival};
        s_axis_tlast <= req.last;
        s_axis_tvalid <= 1'b1;
        gap_left = no_idle ? 0 : rand_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_sink
    int stall_left;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      stall_left = rand_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic queue_request(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] load,
                               input logic last);
    request_t req;
    req.arrival = arr;
    req.load = load;
    req.last = last;
    pending_requests.insert(pending_requests.size(), req);
    requests_queued++;
  endtask

  // Batches of random length with mostly rising arrival times, now and then a
  // jump far up or back, and loads from idle to the longest.
  task automatic queue_random_requests(input int n);
    logic [BUSY_W-1:0] nxt;
    logic [TIME_W-1:0] load;
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 40) nxt = {1'b0, arrival_base};
      else if (r < 80) nxt = {1'b0, arrival_base} + BUSY_W'($urandom_range(1, 20));
      else if (r < 93) nxt = {1'b0, arrival_base} + BUSY_W'($urandom_range(21, 500));
      else if (r < 97) nxt = BUSY_W'($urandom()) & {1'b0, TIME_MAX};
      else nxt = ({1'b0, arrival_base} + BUSY_W'($urandom())) & {1'b0, TIME_MAX};
      if (nxt > {1'b0, TIME_MAX}) nxt = {1'b0, TIME_MAX};
      arrival_base = nxt[TIME_W-1:0];
      r = $urandom_range(0, 99);
      if (r < 10) load = '0;
      else if (r < 65) load = TIME_W'($urandom_range(1, 30));
      else if (r < 88) load = TIME_W'($urandom_range(31, 400));
      else if (r < 96) load = TIME_W'($urandom()) & TIME_MAX;
      else load = TIME_MAX;
      batch_left--;
      queue_request(arrival_base, load, batch_left == 0);
      if (batch_left == 0) begin
        batch_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14);
        arrival_base = ($urandom_range(0, 4) == 0) ? (TIME_W'($urandom()) & TIME_MAX)
                                                   : TIME_W'($urandom_range(0, 1000));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || s_axis_tvalid || requests_seen != requests_queued
           || predicted_results.size() != 0 || !s_axis_tready || m_axis_tvalid);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_server_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_done);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] settings[8];
    clear_servers();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count of servers, field extremes, report at the end.
    queue_request('0, '0, 1'b0);
    queue_request('0, TIME_MAX, 1'b0);
    queue_request(31'd5, 31'd10, 1'b0);
    queue_request(TIME_MAX, TIME_MAX, 1'b1);
    wait_idle();

    // One server: a drop while busy, then the server frees at its end time.
    write_server_count(5'd1);
    queue_request(31'd0, 31'd100, 1'b0);
    queue_request(31'd50, 31'd0, 1'b0);
    queue_request(31'd100, 31'd5, 1'b1);
    wait_idle();

    // A freed server stays free when a later arrival is earlier.
    write_server_count(5'd2);
    queue_request(31'd100, 31'd10, 1'b0);
    queue_request(31'd100, 31'd10, 1'b0);
    queue_request(31'd120, 31'd1000, 1'b0);
    queue_request(31'd50, 31'd5, 1'b0);
    queue_request(31'd50, 31'd5, 1'b1);
    wait_idle();

    // A count of zero acts as one server.
    write_server_count(5'd0);
    queue_request(31'd3, 31'd2, 1'b0);
    queue_request(31'd4, 31'd2, 1'b1);
    wait_idle();

    // Start position beyond a shrunken count, with idle servers keeping state.
    write_server_count(5'd8);
    for (int i = 0; i < 6; i++) queue_request(31'd10, 31'd50, 1'b0);
    wait_idle();
    write_server_count(5'd3);
    queue_request(31'd20, 31'd1, 1'b0);
    queue_request(31'd70, 31'd1, 1'b1);
    wait_idle();

    // Counts above the maximum act as the maximum.
    write_server_count(5'd31);
    queue_request(31'd1, 31'd1, 1'b0);
    queue_request(31'd1, 31'd1, 1'b1);
    wait_idle();

    settings = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16};
    settings[2] = CFG_W'($urandom_range(2, 15));
    for (int p = 0; p < 8; p++) begin
      write_server_count(settings[p]);
      no_idle = (p == 3 || p == 6);
      queue_random_requests(40);
      wait_idle();
    end
    no_idle = 1'b0;
    queue_request(TIME_MAX, '0, 1'b1);
    wait_idle();
    repeat (20) @(negedge clk);

    $display("Ran %0d requests in %0d batches over %0d server-count settings.",
             requests_seen, batches_closed, settings_used);
    $display("Checked %0d results: %0d dropped requests, %0d busiest-server entries.",
             results_seen, drops_seen, report_entries);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", mismatches,
               predicted_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
